// ===== design/sql_statement_end_detector_unit_defines.svh =====
// ----------------------------------------------------------------------------
// SQL statement end detector assertion macros
// Shared property forms for the detector's checks.
// ----------------------------------------------------------------------------
`ifndef SQL_STATEMENT_END_DETECTOR_UNIT_DEFINES_SVH
`define SQL_STATEMENT_END_DETECTOR_UNIT_DEFINES_SVH

// same-cycle implication, reset masked
`define SEDU_ASSERT_NOW(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// next-cycle implication, reset masked
`define SEDU_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== design/sedu_pkg.sv =====
// ----------------------------------------------------------------------------
// sedu_pkg
// Character codes, nesting kinds, line classes and the stack command word.
// ----------------------------------------------------------------------------
package sedu_pkg;

  localparam logic [7:0] CH_NONE   = 8'h00;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [1:0] {
    KIND_PAREN   = 2'd0,
    KIND_COMMENT = 2'd1,
    KIND_DQUOTE  = 2'd2,
    KIND_SQUOTE  = 2'd3
  } nest_kind_t;

  typedef enum logic [1:0] {
    CLS_INCOMPLETE = 2'd0,
    CLS_DOT        = 2'd1,
    CLS_DELIM      = 2'd2,
    CLS_COMPLETE   = 2'd3
  } line_class_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    nest_kind_t kind;
    logic       clear;
  } stack_cmd_t;

endpackage

// ===== design/sedu_stack.sv =====
// ----------------------------------------------------------------------------
// sedu_stack
// Nesting stack: top entry in a register, lower entries in a small memory
// read one entry ahead so a pop refills the top in the same cycle.
// ----------------------------------------------------------------------------
`include "sql_statement_end_detector_unit_defines.svh"

module sedu_stack #(
  parameter int NEST_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  sedu_pkg::stack_cmd_t           cmd,
  output logic [$clog2(NEST_DEPTH+1)-1:0] depth,
  output logic [$clog2(NEST_DEPTH+1)-1:0] depth_upd,
  output sedu_pkg::nest_kind_t           top
);

  localparam int AW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int DW = $clog2(NEST_DEPTH + 1);

  sedu_pkg::nest_kind_t mem [NEST_DEPTH];
  sedu_pkg::nest_kind_t top_r, top_nxt, under_r;
  logic [DW-1:0]        depth_r, depth_nxt, depth_two;
  logic                 do_push, do_pop;

  assign do_push   = cmd.push && (depth_r < DW'(NEST_DEPTH));
  assign do_pop    = cmd.pop && (depth_r != '0);
  assign depth_upd = do_push ? depth_r + DW'(1) :
                     do_pop  ? depth_r - DW'(1) : depth_r;
  assign top_nxt   = do_push ? cmd.kind : do_pop ? under_r : top_r;
  assign depth_nxt = !en ? depth_r : cmd.clear ? '0 : depth_upd;
  assign depth_two = depth_nxt - DW'(2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      top_r <= top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && do_push) begin
      mem[depth_r[AW-1:0]] <= cmd.kind;
    end
    under_r <= mem[depth_two[AW-1:0]];
  end

  assign depth = depth_r;
  assign top   = top_r;

  `SEDU_ASSERT_NOW(a_depth_bound, 1'b1, depth_r <= DW'(NEST_DEPTH), "stack depth out of range")
  `SEDU_ASSERT_NEXT(a_clear_empties, en && cmd.clear, depth_r == '0, "stack not emptied")

endmodule

// ===== design/sedu_track.sv =====
// ----------------------------------------------------------------------------
// sedu_track
// Per-character line state: dot test, comment opener and skip, quote and
// parenthesis nesting, statement end flag and the line class at line end.
// ----------------------------------------------------------------------------
`include "sql_statement_end_detector_unit_defines.svh"

module sedu_track #(
  parameter int NEST_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic [7:0]                      char_code,
  input  logic                            last_char,
  input  logic                            stmt_delim,
  input  logic [$clog2(NEST_DEPTH+1)-1:0] depth,
  input  logic [$clog2(NEST_DEPTH+1)-1:0] depth_upd,
  input  sedu_pkg::nest_kind_t            top,
  output sedu_pkg::stack_cmd_t            cmd,
  output sedu_pkg::line_class_t           line_class
);

  localparam int DW = $clog2(NEST_DEPTH + 1);

  logic       ended_r, ended_upd;
  logic [7:0] prev_r, prev_upd;
  logic [1:0] skip_r, skip_upd;
  logic       pend_r, pend_upd;
  logic       seen_r, seen_upd;
  logic       dot_r, dot_upd;
  logic       ovf_r, ovf_upd;
  logic       open, top_paren, may_open, tracking, is_char;

  assign is_char   = (char_code != sedu_pkg::CH_NONE);
  assign tracking  = is_char && !ovf_r;
  assign open      = (depth != '0);
  assign top_paren = (top == sedu_pkg::KIND_PAREN);
  assign may_open  = !open || top_paren;

  always_comb begin
    cmd       = '{push: 1'b0, pop: 1'b0, kind: sedu_pkg::KIND_PAREN, clear: 1'b0};
    ended_upd = ended_r;
    skip_upd  = skip_r;
    pend_upd  = pend_r;
    ovf_upd   = ovf_r;
    seen_upd  = seen_r;
    dot_upd   = dot_r;
    prev_upd  = is_char ? char_code : prev_r;
    if (is_char && !seen_r && char_code != sedu_pkg::CH_SPACE
        && char_code != sedu_pkg::CH_TAB) begin
      seen_upd = 1'b1;
      dot_upd  = (char_code == sedu_pkg::CH_DOT);
    end
    if (tracking) begin
      if (skip_r != 2'd0) begin
        skip_upd = skip_r - 2'd1;
      end else if (pend_r && char_code == sedu_pkg::CH_STAR) begin
        pend_upd = 1'b0;
        cmd.push = 1'b1;
        cmd.kind = sedu_pkg::KIND_COMMENT;
        skip_upd = 2'd1;
      end else begin
        pend_upd = 1'b0;
        priority if (char_code == sedu_pkg::CH_SPACE || char_code == sedu_pkg::CH_TAB
                     || char_code == sedu_pkg::CH_LF || char_code == sedu_pkg::CH_CR) begin
          ended_upd = ended_r;
        end else if (char_code == sedu_pkg::CH_LPAREN) begin
          cmd.push  = may_open;
          cmd.kind  = sedu_pkg::KIND_PAREN;
          ended_upd = 1'b0;
        end else if (char_code == sedu_pkg::CH_RPAREN) begin
          cmd.pop   = open && top_paren;
          ended_upd = 1'b0;
        end else if (char_code == sedu_pkg::CH_SQUOTE) begin
          cmd.pop   = open && (top == sedu_pkg::KIND_SQUOTE);
          cmd.push  = may_open;
          cmd.kind  = sedu_pkg::KIND_SQUOTE;
          ended_upd = 1'b0;
        end else if (char_code == sedu_pkg::CH_DQUOTE) begin
          cmd.pop   = open && (top == sedu_pkg::KIND_DQUOTE);
          cmd.push  = may_open;
          cmd.kind  = sedu_pkg::KIND_DQUOTE;
          ended_upd = 1'b0;
        end else if (char_code == sedu_pkg::CH_SLASH) begin
          cmd.pop   = open && (top == sedu_pkg::KIND_COMMENT)
                      && (prev_r == sedu_pkg::CH_STAR);
          pend_upd  = may_open;
          ended_upd = 1'b0;
        end else if (char_code == sedu_pkg::CH_SEMI && !open) begin
          ended_upd = 1'b1;
        end else begin
          ended_upd = 1'b0;
        end
      end
      ovf_upd = ovf_r || (depth_upd >= DW'(NEST_DEPTH));
    end
    cmd.clear = last_char;
  end

  always_comb begin
    priority if (dot_upd) begin
      line_class = sedu_pkg::CLS_DOT;
    end else if (stmt_delim) begin
      line_class = sedu_pkg::CLS_DELIM;
    end else if (ovf_upd || (depth_upd == '0 && ended_upd)) begin
      line_class = sedu_pkg::CLS_COMPLETE;
    end else begin
      line_class = sedu_pkg::CLS_INCOMPLETE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ended_r <= 1'b0;
      prev_r  <= '0;
      skip_r  <= '0;
      pend_r  <= 1'b0;
      seen_r  <= 1'b0;
      dot_r   <= 1'b0;
      ovf_r   <= 1'b0;
    end else if (en) begin
      ended_r <= ended_upd && !last_char;
      prev_r  <= last_char ? '0 : prev_upd;
      skip_r  <= last_char ? '0 : skip_upd;
      pend_r  <= pend_upd && !last_char;
      seen_r  <= seen_upd && !last_char;
      dot_r   <= dot_upd && !last_char;
      ovf_r   <= ovf_upd && !last_char;
    end
  end

  `SEDU_ASSERT_NOW(a_skip_or_slash, 1'b1, !(pend_r && skip_r != 2'd0), "slash pending during skip")
  `SEDU_ASSERT_NOW(a_skip_range, 1'b1, skip_r <= 2'd1, "skip count out of range")

endmodule

// ===== design/sql_statement_end_detector_unit.sv =====
// ----------------------------------------------------------------------------
// sql_statement_end_detector_unit
// Classifies one SQL text line streamed one character per word.
// ----------------------------------------------------------------------------
// Takes one character per clock cycle, with no gaps between lines, unless a
// line's last character waits on a stalled output. Each character passes an
// input register, then the nesting and flag update (the tracker and the
// top-of-stack register form a loop), and the word flagged by in_tlast leaves
// a line class in the output register. in_tuser carries the end-delimiter flag
// and is sampled with in_tlast. An output stall only holds a line's last
// character in the input register, which also stops in_tready; others flow on.
`include "sql_statement_end_detector_unit_defines.svh"

module sql_statement_end_detector_unit #(
  parameter int NEST_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  input  logic       in_tlast,
  input  logic       in_tuser,   // [0] stmt_delim
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [1:0] line_class, [7:2] zero
);

  localparam int DW = $clog2(NEST_DEPTH + 1);

  logic                  in_v_r;
  logic [7:0]            char_r;
  logic                  last_r, delim_r;
  logic                  out_v_r;
  sedu_pkg::line_class_t cls_r, cls;
  logic                  proceed;
  sedu_pkg::stack_cmd_t  cmd;
  logic [DW-1:0]         depth, depth_upd;
  sedu_pkg::nest_kind_t  top;

  assign proceed   = in_v_r && (!last_r || !out_v_r || out_tready);
  assign in_tready = !in_v_r || proceed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      char_r  <= in_tdata;
      last_r  <= in_tlast;
      delim_r <= in_tuser;
    end
  end

  sedu_stack #(.NEST_DEPTH(NEST_DEPTH)) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (proceed),
    .cmd       (cmd),
    .depth     (depth),
    .depth_upd (depth_upd),
    .top       (top)
  );

  sedu_track #(.NEST_DEPTH(NEST_DEPTH)) u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (proceed),
    .char_code  (char_r),
    .last_char  (last_r),
    .stmt_delim (delim_r),
    .depth      (depth),
    .depth_upd  (depth_upd),
    .top        (top),
    .cmd        (cmd),
    .line_class (cls)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proceed && last_r) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && last_r) begin
      cls_r <= cls;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'b0, cls_r};

  `SEDU_ASSERT_NEXT(a_line_end_result, proceed && last_r, out_v_r, "line end gave no result")
  `SEDU_ASSERT_NOW(a_no_overwrite, out_v_r && !out_tready, !(proceed && last_r), "result overwritten")

endmodule

// ===== tb/sv/tb_sql_statement_end_detector_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sql_statement_end_detector_unit
// Streams SQL text lines through the detector and checks each line class
// against a cycle-free predictor of the nesting and flag tracking. The sender
// works in bursts and the receiver stalls, with one long hold-off.
// ----------------------------------------------------------------------------
module tb_sql_statement_end_detector_unit;

  localparam int NEST_LIMIT    = 16;
  localparam int TEXT_WORDS    = 1950;
  localparam int RX_HOLD_AT    = 1200;
  localparam int RX_HOLD_LEN   = 400;
  localparam int DRAIN_CYCLES  = 20;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       delim;
  } text_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] char_code
  logic       in_tlast = 1'b0;
  logic       in_tuser = 1'b0;    // [0] stmt_delim
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [1:0] line_class, [7:2] zero

  text_word_t            line_words[$];
  sedu_pkg::line_class_t class_expected[$];
  int                    words_built = 0;
  int                    errors = 0;
  logic [7:0]            blank_chars [4] = '{sedu_pkg::CH_SPACE, sedu_pkg::CH_TAB,
                                             sedu_pkg::CH_CR, sedu_pkg::CH_LF};

  // line tracking state of the predictor
  sedu_pkg::nest_kind_t  nest_kinds [NEST_LIMIT];
  logic [4:0]            open_count;
  logic                  semi_end;
  logic [7:0]            prev_ch;
  logic [1:0]            skip_left;
  logic                  slash_wait;
  logic                  lead_seen;
  logic                  is_directive;
  logic                  overflowed;

  sql_statement_end_detector_unit #(
    .NEST_DEPTH(NEST_LIMIT)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic clear_line_state();
    open_count   = '0;
    semi_end     = 1'b0;
    prev_ch      = sedu_pkg::CH_NONE;
    skip_left    = '0;
    slash_wait   = 1'b0;
    lead_seen    = 1'b0;
    is_directive = 1'b0;
    overflowed   = 1'b0;
  endtask

  task automatic push_nest(input sedu_pkg::nest_kind_t k);
    if (open_count < NEST_LIMIT) begin
      nest_kinds[open_count] = k;
      open_count++;
    end
  endtask

  task automatic track_char(input logic [7:0] c);
    logic                 nested;
    sedu_pkg::nest_kind_t top;
    nested = (open_count != 0);
    top = nested ? nest_kinds[open_count - 1] : sedu_pkg::KIND_PAREN;
    if (skip_left != 0) begin
      skip_left--;
    end else if (slash_wait && c == sedu_pkg::CH_STAR) begin
      slash_wait = 1'b0;
      push_nest(sedu_pkg::KIND_COMMENT);
      skip_left = 2'd1;
      if (open_count >= NEST_LIMIT) overflowed = 1'b1;
    end else begin
      slash_wait = 1'b0;
      case (c)
        sedu_pkg::CH_SPACE, sedu_pkg::CH_TAB, sedu_pkg::CH_LF, sedu_pkg::CH_CR: ;
        sedu_pkg::CH_LPAREN: begin
          if (!nested || top == sedu_pkg::KIND_PAREN) push_nest(sedu_pkg::KIND_PAREN);
          semi_end = 1'b0;
        end
        sedu_pkg::CH_RPAREN: begin
          if (nested && top == sedu_pkg::KIND_PAREN) open_count--;
          semi_end = 1'b0;
        end
        sedu_pkg::CH_SQUOTE: begin
          if (nested && top == sedu_pkg::KIND_SQUOTE) open_count--;
          else if (!nested || top == sedu_pkg::KIND_PAREN) push_nest(sedu_pkg::KIND_SQUOTE);
          semi_end = 1'b0;
        end
        sedu_pkg::CH_DQUOTE: begin
          if (nested && top == sedu_pkg::KIND_DQUOTE) open_count--;
          else if (!nested || top == sedu_pkg::KIND_PAREN) push_nest(sedu_pkg::KIND_DQUOTE);
          semi_end = 1'b0;
        end
        sedu_pkg::CH_SLASH: begin
          if (nested && top == sedu_pkg::KIND_COMMENT) begin
            if (prev_ch == sedu_pkg::CH_STAR) open_count--;
          end else if (!nested || top == sedu_pkg::KIND_PAREN) begin
            slash_wait = 1'b1;
          end
          semi_end = 1'b0;
        end
        sedu_pkg::CH_SEMI: semi_end = (open_count == 0);
        default: semi_end = 1'b0;
      endcase
      if (open_count >= NEST_LIMIT) overflowed = 1'b1;
    end
  endtask

  task automatic predict_word(input logic [7:0] c, input logic last, input logic delim);
    sedu_pkg::line_class_t cls;
    if (c != sedu_pkg::CH_NONE) begin
      if (!lead_seen && c != sedu_pkg::CH_SPACE && c != sedu_pkg::CH_TAB) begin
        lead_seen = 1'b1;
        is_directive = (c == sedu_pkg::CH_DOT);
      end
      if (!overflowed) track_char(c);
      prev_ch = c;
    end
    if (last) begin
      if (is_directive) cls = sedu_pkg::CLS_DOT;
      else if (delim) cls = sedu_pkg::CLS_DELIM;
      else if (overflowed || (open_count == 0 && semi_end)) cls = sedu_pkg::CLS_COMPLETE;
      else cls = sedu_pkg::CLS_INCOMPLETE;
      class_expected.push_back(cls);
      clear_line_state();
    end
  endtask

  task automatic add_word(input logic [7:0] c, input logic last, input logic delim);
    text_word_t w;
    w.ch = c;
    w.last = last;
    w.delim = delim;
    line_words.push_back(w);
    words_built++;
  endtask

  task automatic add_text(input string s, input logic delim);
    for (int i = 0; i < s.len(); i++) add_word(s[i], i == s.len() - 1, delim);
  endtask

  task automatic add_random_line();
    logic [7:0] txt[$];
    int         pick;
    int         k;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      repeat ($urandom_range(1, 12)) txt.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) txt.push_back(blank_chars[2'($urandom_range(0, 1))]);
      if (pick < 18) txt.push_back(sedu_pkg::CH_DOT);
      if (pick >= 18 && pick < 28) begin
        repeat ($urandom_range(13, 18)) begin
          txt.push_back(sedu_pkg::CH_LPAREN);
          if ($urandom_range(0, 3) == 0) txt.push_back(8'($urandom_range(8'h61, 8'h7a)));
        end
      end
      repeat ($urandom_range(1, 10)) begin
        case ($urandom_range(0, 13))
          0: repeat ($urandom_range(1, 5)) txt.push_back(8'($urandom_range(8'h61, 8'h7a)));
          1: txt.push_back(8'($urandom_range(1, 255)));
          2: txt.push_back(blank_chars[2'($urandom_range(0, 3))]);
          3: txt.push_back(sedu_pkg::CH_LPAREN);
          4: txt.push_back(sedu_pkg::CH_RPAREN);
          5: txt.push_back(sedu_pkg::CH_SQUOTE);
          6: txt.push_back(sedu_pkg::CH_DQUOTE);
          7: begin
            txt.push_back(sedu_pkg::CH_SLASH);
            txt.push_back(sedu_pkg::CH_STAR);
          end
          8: begin
            txt.push_back(sedu_pkg::CH_STAR);
            txt.push_back(sedu_pkg::CH_SLASH);
          end
          9: txt.push_back(sedu_pkg::CH_SLASH);
          10: txt.push_back(sedu_pkg::CH_STAR);
          11: txt.push_back(sedu_pkg::CH_SEMI);
          12: begin
            txt.push_back(sedu_pkg::CH_SQUOTE);
            repeat ($urandom_range(0, 4)) txt.push_back(8'($urandom_range(8'h20, 8'h7e)));
            txt.push_back(sedu_pkg::CH_SQUOTE);
          end
          default: txt.push_back(sedu_pkg::CH_NONE);
        endcase
      end
      k = $urandom_range(0, 9);
      if (k < 5) txt.push_back(sedu_pkg::CH_SEMI);
      if (k == 1 || k == 2) begin
        txt.push_back(sedu_pkg::CH_CR);
        txt.push_back(sedu_pkg::CH_LF);
      end
    end
    if (txt.size() == 0) txt.push_back(sedu_pkg::CH_NONE);
    foreach (txt[i]) add_word(txt[i], i == txt.size() - 1, $urandom_range(0, 9) == 0);
  endtask

  // sender: bursts of words separated by random gaps
  int         burst_left;
  int         gap_left;
  text_word_t next_word;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= 8'h00;
      in_tlast <= 1'b0;
      in_tuser <= 1'b0;
      clear_line_state();
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) predict_word(in_tdata, in_tlast, in_tuser);
      if (!in_tvalid || in_tready) begin
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap_left > 0 || line_words.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          next_word = line_words.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= next_word.ch;
          in_tlast <= next_word.last;
          in_tuser <= next_word.delim;
          burst_left--;
        end
      end
    end
  end

  // receiver: randomly redrawn stall pattern, one long hold-off
  int rx_cycles;
  int rx_mode;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_cycles = 0;
      rx_mode = 0;
    end else begin
      rx_cycles++;
      if (rx_cycles % 100 == 0) rx_mode = $urandom_range(0, 3);
      if (rx_cycles >= RX_HOLD_AT && rx_cycles < RX_HOLD_AT + RX_HOLD_LEN) begin
        out_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 9) < 3);
          default: out_tready <= (rx_cycles % 4 == 0);
        endcase
      end
    end
  end

  sedu_pkg::line_class_t want_class;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (class_expected.size() == 0) begin
        $display("%0t: unexpected line class word, expected none, actual %h", $time,
                 out_tdata);
        errors++;
      end else begin
        want_class = class_expected.pop_front();
        if (out_tdata !== {6'b0, want_class}) begin
          $display("%0t: line class mismatch, expected %h, actual %h", $time,
                   {6'b0, want_class}, out_tdata);
          errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    add_word(sedu_pkg::CH_NONE, 1'b1, 1'b0);
    add_word(sedu_pkg::CH_NONE, 1'b1, 1'b1);
    add_text(" \t.", 1'b1);
    add_text("x;\r\n", 1'b0);
    add_text("/*;*/;", 1'b0);
    add_text("(\"(\")/", 1'b0);
    add_text("(((((((((((((((((;", 1'b0);
    add_word(8'hFF, 1'b1, 1'b0);
    while (words_built < TEXT_WORDS) add_random_line();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (line_words.size() != 0 || in_tvalid) @(posedge clk);
    while (class_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
